>>> hdl/kprw_pkg.sv
package kprw_pkg;

    localparam int MAX_HISTORY = 64;
    localparam int DATA_W      = 32;
    localparam int ELAPSED_W   = 20;
    localparam int INTERVAL_W  = 26;
    localparam int LIMIT_W     = 7;
    localparam int MODE_W      = 2;

    // Sample count runs from 0 to MAX_HISTORY inclusive.
    localparam int CNT_W     = $clog2(MAX_HISTORY + 1);
    localparam int IDX_W     = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
    localparam int SUM_W     = DATA_W + CNT_W;
    // The divider retires two quotient bits a cycle, so the dividend is padded to even.
    localparam int DIV_W     = 2 * ((SUM_W + 1) / 2);
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PONG  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 26'd1000000;
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 7'd64;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } scan_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] last;
        logic [DATA_W-1:0] avg;
        logic [DATA_W-1:0] min_v;
        logic [DATA_W-1:0] max_v;
    } rtt_stats_t;

    // Window limit clamped to 1..MAX_HISTORY.
    function automatic logic [CNT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] lim);
        if (lim == '0)
        begin
            return CNT_W'(1);
        end
        else if (int'(lim) > MAX_HISTORY)
        begin
            return CNT_W'(MAX_HISTORY);
        end
        else
        begin
            return CNT_W'(lim);
        end
    endfunction

endpackage

>>> hdl/kprw_cell.sv
module kprw_cell (
    input  logic                         clk,
    input  logic                         shift,
    input  logic [kprw_pkg::DATA_W-1:0]  din,
    output logic [kprw_pkg::DATA_W-1:0]  dout
);

    logic [kprw_pkg::DATA_W-1:0] sample_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            sample_reg <= din;
        end
    end

    assign dout = sample_reg;

endmodule

>>> hdl/kprw_div.sv
module kprw_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [kprw_pkg::SUM_W-1:0]    dividend,
    input  logic [kprw_pkg::CNT_W-1:0]    divisor,
    output logic                          done,
    output logic [kprw_pkg::DATA_W-1:0]   quotient
);

    localparam int CW = kprw_pkg::CNT_W;
    localparam int DW = kprw_pkg::DIV_W;

    logic                              busy_reg;
    logic                              busy_next;
    logic [kprw_pkg::DCNT_W-1:0]       cnt_reg;
    logic [kprw_pkg::DCNT_W-1:0]       cnt_next;
    logic                              done_reg;
    logic                              done_next;
    logic [CW-1:0]                     rem_reg;
    logic [CW-1:0]                     rem_next;
    logic [DW-1:0]                     q_reg;
    logic [DW-1:0]                     q_next;
    logic [CW-1:0]                     d_reg;
    logic [CW:0]                       step1;
    logic [CW:0]                       step2;

    // One restoring step: the partial remainder always stays below the divisor.
    function automatic logic [CW:0] div_step(input logic [CW-1:0] rem,
                                             input logic          bit_in,
                                             input logic [CW-1:0] d);
        logic [CW:0] t;
        logic [CW:0] diff;
        t    = {rem, bit_in};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
        begin
            return {diff[CW-1:0], 1'b1};
        end
        else
        begin
            return {t[CW-1:0], 1'b0};
        end
    endfunction

    always_comb
    begin
        step1     = div_step(rem_reg, q_reg[DW-1], d_reg);
        step2     = div_step(step1[CW:1], q_reg[DW-2], d_reg);
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = DW'(dividend);
        end
        else if (busy_reg)
        begin
            rem_next = step2[CW:1];
            q_next   = {q_reg[DW-3:0], step1[0], step2[0]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == kprw_pkg::DCNT_W'(kprw_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg[kprw_pkg::DATA_W-1:0];

endmodule

>>> hdl/kprw_stats.sv
module kprw_stats (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kprw_pkg::scan_req_t           req,
    input  logic [kprw_pkg::DATA_W-1:0]   tap,
    output logic                          rotate,
    output logic                          done,
    output kprw_pkg::rtt_stats_t          stats
);

    localparam int CW = kprw_pkg::CNT_W;

    logic                              scan_reg;
    logic                              scan_next;
    logic [kprw_pkg::IDX_W-1:0]        step_reg;
    logic [kprw_pkg::IDX_W-1:0]        step_next;
    logic                              div_start_reg;
    logic                              div_start_next;
    logic [CW-1:0]                     cnt_reg;
    logic [kprw_pkg::SUM_W-1:0]        sum_reg;
    logic [kprw_pkg::SUM_W-1:0]        sum_next;
    logic [kprw_pkg::DATA_W-1:0]       min_reg;
    logic [kprw_pkg::DATA_W-1:0]       min_next;
    logic [kprw_pkg::DATA_W-1:0]       max_reg;
    logic [kprw_pkg::DATA_W-1:0]       max_next;
    logic [kprw_pkg::DATA_W-1:0]       last_reg;
    logic [kprw_pkg::DATA_W-1:0]       last_next;
    logic                              last_step;
    logic                              tap_valid;
    logic [kprw_pkg::DATA_W-1:0]       quotient;

    // At scan step j the tail cell holds the entry that started at place
    // MAX_HISTORY-1-j; it lies inside the window once j + count reaches the depth.
    assign last_step = (step_reg == kprw_pkg::IDX_W'(kprw_pkg::MAX_HISTORY - 1));
    assign tap_valid = ({1'b0, CW'(step_reg)} + {1'b0, cnt_reg})
                       >= (CW + 1)'(kprw_pkg::MAX_HISTORY);

    always_comb
    begin
        scan_next      = scan_reg;
        step_next      = step_reg;
        div_start_next = 1'b0;
        sum_next       = sum_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        last_next      = last_reg;
        if (req.start)
        begin
            scan_next = 1'b1;
            step_next = '0;
            sum_next  = '0;
            min_next  = '1;
            max_next  = '0;
        end
        else if (scan_reg)
        begin
            step_next = step_reg + 1'b1;
            if (tap_valid)
            begin
                sum_next = sum_reg + kprw_pkg::SUM_W'(tap);
                if (tap < min_reg)
                begin
                    min_next = tap;
                end
                if (tap > max_reg)
                begin
                    max_next = tap;
                end
            end
            if (last_step)
            begin
                scan_next      = 1'b0;
                div_start_next = 1'b1;
                last_next      = tap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg      <= 1'b0;
            step_reg      <= '0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            scan_reg      <= scan_next;
            step_reg      <= step_next;
            div_start_reg <= div_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        min_reg  <= min_next;
        max_reg  <= max_next;
        last_reg <= last_next;
        if (req.start)
        begin
            cnt_reg <= req.count;
        end
    end

    kprw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (done),
        .quotient (quotient)
    );

    assign rotate      = scan_reg;
    assign stats.last  = last_reg;
    assign stats.avg   = quotient;
    assign stats.min_v = min_reg;
    assign stats.max_v = max_reg;

endmodule

>>> hdl/keepalive_ping_rtt_window_core.sv
// Channel   Signals                              Transfer when
// item      item_valid / item_stall, 3 fields    item_valid && !item_stall
// result    result_valid / result_stall, 8 fields result_valid && !result_stall
// config    APB: psel penable pwrite paddr ...   psel && penable && pwrite && pready
//
// An item that leaves the window empty passes straight from ST_IDLE to ST_OUT.
// Otherwise the window ring is rotated once through all MAX_HISTORY cells and the mean
// comes from a two-bit-a-cycle divider. item_stall is high from the transfer until the
// result is in the output register. Reset clears all control state at once; window
// cells hold no reset value and are only read inside the current count.
module keepalive_ping_rtt_window_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [kprw_pkg::MODE_W-1:0]       mode,
    input  logic [kprw_pkg::ELAPSED_W-1:0]    elapsed_us,
    input  logic [kprw_pkg::DATA_W-1:0]       now_ms,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              send_ping,
    output logic [kprw_pkg::DATA_W-1:0]       ping_stamp,
    output logic                              awaiting_pong,
    output logic [kprw_pkg::CNT_W-1:0]        sample_count,
    output logic [kprw_pkg::DATA_W-1:0]       last_rtt_ms,
    output logic [kprw_pkg::DATA_W-1:0]       avg_rtt_ms,
    output logic [kprw_pkg::DATA_W-1:0]       min_rtt_ms,
    output logic [kprw_pkg::DATA_W-1:0]       max_rtt_ms,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int DW = kprw_pkg::DATA_W;
    localparam int N  = kprw_pkg::MAX_HISTORY;
    localparam int CW = kprw_pkg::CNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_STATS = 2'd1;
    localparam logic [1:0] ST_OUT   = 2'd2;

    localparam logic REG_INTERVAL = 1'b0;
    localparam logic REG_LIMIT    = 1'b1;

    logic [1:0]                        state_reg;
    logic [1:0]                        state_next;
    logic [kprw_pkg::INTERVAL_W-1:0]   interval_reg;
    logic [kprw_pkg::INTERVAL_W-1:0]   interval_next;
    logic [kprw_pkg::LIMIT_W-1:0]      limit_reg;
    logic [kprw_pkg::LIMIT_W-1:0]      limit_next;
    logic [DW-1:0]                     accum_reg;
    logic [DW-1:0]                     accum_next;
    logic [DW-1:0]                     sent_reg;
    logic [DW-1:0]                     sent_next;
    logic                              pending_reg;
    logic                              pending_next;
    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     count_next;
    logic                              start_reg;
    logic                              start_next;
    logic                              res_send_reg;
    logic                              res_send_next;
    logic [DW-1:0]                     res_stamp_reg;
    logic [DW-1:0]                     res_stamp_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              out_send_reg;
    logic [DW-1:0]                     out_stamp_reg;
    logic                              out_await_reg;
    logic [CW-1:0]                     out_count_reg;
    kprw_pkg::rtt_stats_t              out_stats_reg;

    logic                              accept;
    logic                              cfg_write;
    logic                              load_out;
    logic                              push;
    logic                              rotate;
    logic                              stats_done;
    logic [DW:0]                       accum_sum;
    logic [DW-1:0]                     accum_sat;
    logic [DW-1:0]                     rtt;
    logic [CW-1:0]                     limit_eff;
    kprw_pkg::scan_req_t               req;
    kprw_pkg::rtt_stats_t              stats;
    logic [DW-1:0]                     cell_dout [N];
    logic [DW-1:0]                     cell_din  [N];

    assign accept    = item_valid && (state_reg == ST_IDLE);
    assign cfg_write = psel && penable && pwrite;
    assign load_out  = (state_reg == ST_OUT) && (!out_valid_reg || !result_stall);
    assign push      = accept && (mode == kprw_pkg::MODE_PONG) && pending_reg;

    assign accum_sum = {1'b0, accum_reg} + (DW + 1)'(elapsed_us);
    assign accum_sat = accum_sum[DW] ? '1 : accum_sum[DW-1:0];
    assign rtt       = now_ms - sent_reg;
    assign limit_eff = kprw_pkg::eff_limit(limit_reg);

    always_comb
    begin
        state_next     = state_reg;
        interval_next  = interval_reg;
        limit_next     = limit_reg;
        accum_next     = accum_reg;
        sent_next      = sent_reg;
        pending_next   = pending_reg;
        count_next     = count_reg;
        start_next     = 1'b0;
        res_send_next  = res_send_reg;
        res_stamp_next = res_stamp_reg;
        out_valid_next = out_valid_reg;

        if (result_valid && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_send_next  = 1'b0;
                    res_stamp_next = '0;
                    case (mode)
                        kprw_pkg::MODE_TICK:
                        begin
                            accum_next = accum_sat;
                            if ((accum_sat >= DW'(interval_reg)) && !pending_reg)
                            begin
                                res_send_next  = 1'b1;
                                res_stamp_next = now_ms;
                                sent_next      = now_ms;
                                pending_next   = 1'b1;
                                accum_next     = '0;
                            end
                        end
                        kprw_pkg::MODE_PONG:
                        begin
                            if (pending_reg)
                            begin
                                pending_next = 1'b0;
                                if (count_reg < limit_eff)
                                begin
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        end
                        kprw_pkg::MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (count_next != '0)
                    begin
                        state_next = ST_STATS;
                        start_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_STATS:
            begin
                if (stats_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            case (paddr[2])
                REG_INTERVAL:
                begin
                    interval_next = pwdata[kprw_pkg::INTERVAL_W-1:0];
                end
                REG_LIMIT:
                begin
                    limit_next = pwdata[kprw_pkg::LIMIT_W-1:0];
                    if (pwdata[kprw_pkg::LIMIT_W-1:0] != limit_reg)
                    begin
                        count_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            interval_reg  <= kprw_pkg::INTERVAL_RESET;
            limit_reg     <= kprw_pkg::LIMIT_RESET;
            accum_reg     <= '0;
            sent_reg      <= '0;
            pending_reg   <= 1'b0;
            count_reg     <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            interval_reg  <= interval_next;
            limit_reg     <= limit_next;
            accum_reg     <= accum_next;
            sent_reg      <= sent_next;
            pending_reg   <= pending_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_send_reg  <= res_send_next;
        res_stamp_reg <= res_stamp_next;
        if (load_out)
        begin
            out_send_reg  <= res_send_reg;
            out_stamp_reg <= res_stamp_reg;
            out_await_reg <= pending_reg;
            out_count_reg <= count_reg;
            if (count_reg == '0)
            begin
                out_stats_reg <= '0;
            end
            else
            begin
                out_stats_reg <= stats;
            end
        end
    end

    // Window ring: cell 0 holds the newest sample. A new sample shifts the row
    // along; during a scan the tail feeds back into cell 0 so a full turn
    // leaves every sample where it was.
    assign cell_din[0] = push ? rtt : cell_dout[N-1];

    genvar gi;
    generate
        for (gi = 1; gi < N; gi++)
        begin : g_link
            assign cell_din[gi] = cell_dout[gi-1];
        end
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            kprw_cell u_cell (
                .clk   (clk),
                .shift (push || rotate),
                .din   (cell_din[gi]),
                .dout  (cell_dout[gi])
            );
        end
    endgenerate

    assign req.start = start_reg;
    assign req.count = count_reg;

    kprw_stats u_stats (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .tap    (cell_dout[N-1]),
        .rotate (rotate),
        .done   (stats_done),
        .stats  (stats)
    );

    assign item_stall    = (state_reg != ST_IDLE);
    assign result_valid  = out_valid_reg;
    assign send_ping     = out_send_reg;
    assign ping_stamp    = out_stamp_reg;
    assign awaiting_pong = out_await_reg;
    assign sample_count  = out_count_reg;
    assign last_rtt_ms   = out_stats_reg.last;
    assign avg_rtt_ms    = out_stats_reg.avg;
    assign min_rtt_ms    = out_stats_reg.min_v;
    assign max_rtt_ms    = out_stats_reg.max_v;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LIMIT) ? 32'(limit_reg) : 32'(interval_reg);

endmodule

>>> hdl/kprw_checker.sv
module kprw_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  logic                              send_ping,
    input  logic [kprw_pkg::DATA_W-1:0]       ping_stamp,
    input  logic                              awaiting_pong,
    input  logic [kprw_pkg::CNT_W-1:0]        sample_count,
    input  logic [kprw_pkg::DATA_W-1:0]       last_rtt_ms,
    input  logic [kprw_pkg::DATA_W-1:0]       avg_rtt_ms,
    input  logic [kprw_pkg::DATA_W-1:0]       min_rtt_ms,
    input  logic [kprw_pkg::DATA_W-1:0]       max_rtt_ms
);

    // A stalled result stays on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result withdrawn while stalled");

    // A ping request always leaves a pong outstanding, and carries a stamp only then.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((send_ping && awaiting_pong) || (!send_ping && ping_stamp == '0)))
        else $error("ping request inconsistent with pending state");

    // An empty window reports zero statistics.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (sample_count == '0) |->
            (last_rtt_ms == '0) && (avg_rtt_ms == '0) && (min_rtt_ms == '0)
            && (max_rtt_ms == '0))
        else $error("statistics not zero for empty window");

    // The mean and the newest sample lie between the minimum and the maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (sample_count != '0) |->
            (min_rtt_ms <= avg_rtt_ms) && (avg_rtt_ms <= max_rtt_ms)
            && (min_rtt_ms <= last_rtt_ms) && (last_rtt_ms <= max_rtt_ms))
        else $error("window statistics out of order");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (int'(sample_count) <= kprw_pkg::MAX_HISTORY))
        else $error("sample count beyond window depth");

endmodule

bind keepalive_ping_rtt_window_core kprw_checker u_kprw_checker (.*);
